// ===== src/hbsf_pkg.sv =====
// Shared types and constants for the zero-bit insertion framer.
// No dependencies; imported by every module of the block.
package hbsf_pkg;

    // Default flag length in line bits
    localparam int FLAG_BITS_DEFAULT = 8;
    // Depth of the command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Register widths and reset values
    localparam int FLAG_REG_W  = 8;
    localparam int LIMIT_REG_W = 4;
    localparam logic [FLAG_REG_W-1:0]  FLAG_RESET  = 8'h7E;
    localparam logic [LIMIT_REG_W-1:0] LIMIT_RESET = 4'd5;

    // Configuration register indexes
    localparam logic CFG_FLAG_PATTERN = 1'b0;
    localparam logic CFG_RUN_LIMIT    = 1'b1;

    // Line bit kinds
    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_STUFF = 2'd1,
        KIND_FLAG  = 2'd2
    } t_kind;

    // Serializer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_OPEN,
        PH_DATA,
        PH_STUFF,
        PH_CLOSE
    } t_phase;

    // Classified item handed from front to back
    typedef struct packed {
        logic data_bit;
        logic open_flag;
        logic stuff;
        logic close_flag;
    } t_cmd;

endpackage

// ===== src/hdlc_bit_stuff_framer_unit.sv =====
// Zero-bit insertion framer top level: config registers, front, queue, back.
// An accepted input passes through the queue into the serializer output register.
// Throughput: one line bit per cycle while i_out_stall is low, set by the serializer output register;
// an item yields 1 data line bit, plus FLAG_BITS line bits per flag and 1 per stuffed zero.
// Reset (synchronous, active low) empties the queue, closes the frame,
// clears the ones run and loads flag 0x7E and run limit 5.
module hdlc_bit_stuff_framer_unit #(
    parameter int FLAG_BITS = hbsf_pkg::FLAG_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic                            i_cfg_index,
    input  logic [hbsf_pkg::FLAG_REG_W-1:0] i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_bit_in,
    input  logic                            i_last_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_bit_out,
    output logic [1:0]                      o_bit_kind,
    output logic                            o_run_last
);
    import hbsf_pkg::*;

    logic [FLAG_REG_W-1:0]  r_flag_pattern;
    logic [LIMIT_REG_W-1:0] r_run_limit;
    logic                   push, pop, q_full, q_valid;
    t_cmd                   push_cmd, head_cmd;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag_pattern <= FLAG_RESET;
            r_run_limit    <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_FLAG_PATTERN: r_flag_pattern <= i_cfg_wdata;
                CFG_RUN_LIMIT:    r_run_limit    <= i_cfg_wdata[LIMIT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    hbsf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_bit_in     (i_bit_in),
        .i_last_in    (i_last_in),
        .i_run_limit  (r_run_limit),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    hbsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    hbsf_back #(
        .FLAG_BITS (FLAG_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_flag_pattern (r_flag_pattern),
        .i_cmd_valid    (q_valid),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_bit_out      (o_bit_out),
        .o_bit_kind     (o_bit_kind),
        .o_run_last     (o_run_last)
    );

endmodule

// ===== src/hbsf_front.sv =====
// Front end: accepts payload bits, tracks frame and ones-run state,
// and classifies each item into a command. Depends on hbsf_pkg.
module hbsf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_bit_in,
    input  logic                          i_last_in,
    input  logic [hbsf_pkg::LIMIT_REG_W-1:0] i_run_limit,
    input  logic                          i_queue_full,
    output logic                          o_push,
    output hbsf_pkg::t_cmd                o_cmd
);
    import hbsf_pkg::*;

    logic                   r_in_frame, n_in_frame;
    logic [LIMIT_REG_W-1:0] r_ones, n_ones;
    logic [LIMIT_REG_W-1:0] start_ones;
    logic [LIMIT_REG_W-1:0] inc_ones;
    logic                   stuff;
    logic                   accept;

    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;
    assign o_push     = accept;

    // Classification: opening flag, stuffed zero, closing flag
    always_comb begin
        start_ones = r_in_frame ? r_ones : '0;
        inc_ones   = start_ones + LIMIT_REG_W'(1);
        stuff      = i_bit_in && (inc_ones == i_run_limit);

        o_cmd.data_bit   = i_bit_in;
        o_cmd.open_flag  = !r_in_frame;
        o_cmd.stuff      = stuff;
        o_cmd.close_flag = i_last_in;

        n_in_frame = !i_last_in;
        if (i_last_in || !i_bit_in || stuff) begin
            n_ones = '0;
        end else begin
            n_ones = inc_ones;
        end
    end

    // Frame state updates on each accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_ones     <= '0;
        end else if (accept) begin
            r_in_frame <= n_in_frame;
            r_ones     <= n_ones;
        end
    end

endmodule

// ===== src/hbsf_queue.sv =====
// Small command FIFO decoupling the classifier from the serializer.
// Depends on hbsf_pkg for the command type and depth.
module hbsf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  hbsf_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output hbsf_pkg::t_cmd o_cmd
);
    import hbsf_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          do_pop;

    assign o_full  = (r_count == CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rptr];
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wptr + AW'(1);
            end
            if (do_pop) begin
                r_rptr <= (r_rptr == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rptr + AW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

// ===== src/hbsf_back.sv =====
// Back end: serializes commands into line bits (flags, data, stuffed zeros)
// into a registered output stage. Depends on hbsf_pkg.
module hbsf_back #(
    parameter int FLAG_BITS = hbsf_pkg::FLAG_BITS_DEFAULT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [hbsf_pkg::FLAG_REG_W-1:0] i_flag_pattern,
    input  logic                            i_cmd_valid,
    input  hbsf_pkg::t_cmd                  i_cmd,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_bit_out,
    output logic [1:0]                      o_bit_kind,
    output logic                            o_run_last
);
    import hbsf_pkg::*;

    localparam int CNT_W  = (FLAG_BITS > 1) ? $clog2(FLAG_BITS) : 1;
    localparam int FLAG_W = (FLAG_BITS > FLAG_REG_W) ? FLAG_BITS : FLAG_REG_W;
    localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(FLAG_BITS - 1);

    t_phase            r_phase, n_phase;
    t_cmd              r_cur, n_cur;
    logic [CNT_W-1:0]  r_cnt, n_cnt;

    t_phase            e_phase;
    t_cmd              e_cmd;
    logic [CNT_W-1:0]  e_cnt;
    logic              e_valid;
    logic              can_load;
    logic              fire;
    logic              done;
    logic [FLAG_W-1:0] flag_ext;

    logic              r_out_valid;
    logic              r_bit;
    t_kind             r_kind;
    logic              r_last;
    logic              emit_bit;
    t_kind             emit_kind;

    // Flag positions above the register width go out as zero
    assign flag_ext = FLAG_W'(i_flag_pattern);
    assign can_load = !r_out_valid || !i_out_stall;

    // Current work: a fresh command from the queue when idle
    always_comb begin
        if (r_phase == PH_IDLE) begin
            e_valid = i_cmd_valid;
            e_cmd   = i_cmd;
            e_phase = i_cmd.open_flag ? PH_OPEN : PH_DATA;
            e_cnt   = CNT_TOP;
        end else begin
            e_valid = 1'b1;
            e_cmd   = r_cur;
            e_phase = r_phase;
            e_cnt   = r_cnt;
        end
        fire  = e_valid && can_load;
        o_pop = fire && (r_phase == PH_IDLE);
    end

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_cur   = e_cmd;
        n_cnt   = r_cnt;
        done    = 1'b0;
        case (e_phase)
            PH_OPEN: begin
                if (e_cnt == '0) begin
                    n_phase = PH_DATA;
                end else begin
                    n_phase = PH_OPEN;
                    n_cnt   = e_cnt - CNT_W'(1);
                end
            end
            PH_DATA: begin
                if (e_cmd.stuff) begin
                    n_phase = PH_STUFF;
                end else if (e_cmd.close_flag) begin
                    n_phase = PH_CLOSE;
                    n_cnt   = CNT_TOP;
                end else begin
                    done = 1'b1;
                end
            end
            PH_STUFF: begin
                if (e_cmd.close_flag) begin
                    n_phase = PH_CLOSE;
                    n_cnt   = CNT_TOP;
                end else begin
                    done = 1'b1;
                end
            end
            PH_CLOSE: begin
                if (e_cnt == '0) begin
                    done = 1'b1;
                end else begin
                    n_phase = PH_CLOSE;
                    n_cnt   = e_cnt - CNT_W'(1);
                end
            end
            default: begin
                done = 1'b1;
            end
        endcase
        if (done) begin
            n_phase = PH_IDLE;
        end
    end

    // Line bit for the current phase
    always_comb begin
        case (e_phase)
            PH_OPEN, PH_CLOSE: begin
                emit_bit  = flag_ext[e_cnt];
                emit_kind = KIND_FLAG;
            end
            PH_DATA: begin
                emit_bit  = e_cmd.data_bit;
                emit_kind = KIND_DATA;
            end
            PH_STUFF: begin
                emit_bit  = 1'b0;
                emit_kind = KIND_STUFF;
            end
            default: begin
                emit_bit  = 1'b0;
                emit_kind = KIND_DATA;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else if (fire) begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_cur <= n_cur;
            r_cnt <= n_cnt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (can_load) begin
            r_out_valid <= e_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_bit  <= emit_bit;
            r_kind <= emit_kind;
            r_last <= done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_bit_out   = r_bit;
    assign o_bit_kind  = r_kind;
    assign o_run_last  = r_last;

endmodule
